FILE: rtl/bps_pkg.sv
// shared types and codes for the breakpoint slot table
package bps_pkg;

    // request function codes as they arrive on the func port
    localparam logic [1:0] FUNC_INSERT     = 2'd0;
    localparam logic [1:0] FUNC_REMOVE     = 2'd1;
    localparam logic [1:0] FUNC_ACTIVATE   = 2'd2;
    localparam logic [1:0] FUNC_DEACTIVATE = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_UNDEF   = 2'd0;
    localparam logic [1:0] SLOT_SET     = 2'd1;
    localparam logic [1:0] SLOT_ACTIVE  = 2'd2;
    localparam logic [1:0] SLOT_REMOVED = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNABLE    = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_KIND      = 2'd3;

    // patch actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_INSTALL = 2'd1;
    localparam logic [1:0] ACT_RESTORE = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_REJECT,
        OP_ACTIVATE,
        OP_DEACTIVATE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] address;
    } cmd_t;

endpackage

FILE: rtl/bps_front.sv
// request intake: classifies each request and queues it for the back end
module bps_front
    import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  func,
    input  logic [31:0] address,
    input  logic        kind,
    output logic        busy,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    always_comb
    begin
        new_cmd.address = address;
        unique case (func)
            FUNC_INSERT:     new_cmd.op = OP_INSERT;
            FUNC_REMOVE:     new_cmd.op = kind ? OP_REJECT : OP_REMOVE;
            FUNC_ACTIVATE:   new_cmd.op = OP_ACTIVATE;
            FUNC_DEACTIVATE: new_cmd.op = OP_DEACTIVATE;
            default:         new_cmd.op = OP_INSERT;
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: rtl/bps_back.sv
// execution engine: scans the slot table and emits results; a remove of the wrong kind is answered without a scan
module bps_back
    import bps_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  slot,
    output logic [31:0] patch_address,
    output logic [1:0]  patch_action,
    output logic        last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } fsm_t;

    fsm_t          state_reg;
    op_t           op_reg;
    logic [31:0]   addr_reg;
    logic [CW-1:0] cnt_reg;
    logic          s1_valid_reg;
    logic [IW-1:0] s1_idx_reg;
    logic [1:0]    slot_state_reg [NUM_SLOTS];
    logic          set_found_reg;
    logic [IW-1:0] set_idx_reg;
    logic          rem_found_reg;
    logic [IW-1:0] rem_idx_reg;
    logic          und_found_reg;
    logic [IW-1:0] und_idx_reg;

    logic          done_reg;
    logic [1:0]    status_reg;
    logic [3:0]    slot_reg;
    logic [31:0]   patch_address_reg;
    logic [1:0]    patch_action_reg;
    logic          last_reg;

    logic [31:0]   mem [NUM_SLOTS];
    logic [31:0]   rd_data_reg;

    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic          mem_we;
    logic [IW-1:0] ins_idx;
    logic          ins_ok;
    logic [1:0]    s1_state;
    logic          s1_hit;
    logic          walking;
    logic          walk_hit;
    logic [1:0]    walk_from;
    logic [1:0]    walk_to;
    logic [1:0]    walk_action;
    logic [1:0]    fin_status;
    logic [3:0]    fin_slot;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign rd_en    = (state_reg == S_SCAN) && (cnt_reg < LAST_CNT);
    assign rd_idx   = cnt_reg[IW-1:0];
    assign s1_state = slot_state_reg[s1_idx_reg];
    assign s1_hit   = (s1_state == SLOT_SET) && (rd_data_reg == addr_reg);
    assign walking  = (op_reg == OP_ACTIVATE) || (op_reg == OP_DEACTIVATE);
    assign walk_hit = s1_valid_reg && walking && (s1_state == walk_from);
    assign ins_idx  = rem_found_reg ? rem_idx_reg : und_idx_reg;
    assign ins_ok   = !set_found_reg && (rem_found_reg || und_found_reg);
    assign mem_we   = (state_reg == S_FINISH) && (op_reg == OP_INSERT) && ins_ok;

    always_comb
    begin
        if (op_reg == OP_ACTIVATE)
        begin
            walk_from   = SLOT_SET;
            walk_to     = SLOT_ACTIVE;
            walk_action = ACT_INSTALL;
        end
        else
        begin
            walk_from   = SLOT_ACTIVE;
            walk_to     = SLOT_SET;
            walk_action = ACT_RESTORE;
        end
    end

    // closing result of insert, remove and the walks
    always_comb
    begin
        fin_status = STATUS_OK;
        fin_slot   = '0;
        if (op_reg == OP_INSERT)
        begin
            if (ins_ok)
            begin
                fin_slot = 4'(ins_idx);
            end
            else
            begin
                fin_status = STATUS_UNABLE;
            end
        end
        else if (op_reg == OP_REMOVE)
        begin
            if (set_found_reg)
            begin
                fin_slot = 4'(set_idx_reg);
            end
            else
            begin
                fin_status = STATUS_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= OP_INSERT;
            addr_reg          <= '0;
            cnt_reg           <= '0;
            s1_valid_reg      <= 1'b0;
            s1_idx_reg        <= '0;
            set_found_reg     <= 1'b0;
            set_idx_reg       <= '0;
            rem_found_reg     <= 1'b0;
            rem_idx_reg       <= '0;
            und_found_reg     <= 1'b0;
            und_idx_reg       <= '0;
            done_reg          <= 1'b0;
            status_reg        <= STATUS_OK;
            slot_reg          <= '0;
            patch_address_reg <= '0;
            patch_action_reg  <= ACT_NONE;
            last_reg          <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= SLOT_UNDEF;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg        <= q_cmd.op;
                        addr_reg      <= q_cmd.address;
                        cnt_reg       <= '0;
                        s1_valid_reg  <= 1'b0;
                        set_found_reg <= 1'b0;
                        rem_found_reg <= 1'b0;
                        und_found_reg <= 1'b0;
                        if (q_cmd.op == OP_REJECT)
                        begin
                            // wrong breakpoint kind: answer at once, table untouched
                            done_reg          <= 1'b1;
                            status_reg        <= STATUS_KIND;
                            slot_reg          <= '0;
                            patch_address_reg <= '0;
                            patch_action_reg  <= ACT_NONE;
                            last_reg          <= 1'b1;
                        end
                        else
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        s1_valid_reg <= 1'b1;
                        s1_idx_reg   <= rd_idx;
                        cnt_reg      <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        s1_valid_reg <= 1'b0;
                        if (!s1_valid_reg)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    done_reg <= walk_hit;
                    if (walk_hit)
                    begin
                        slot_state_reg[s1_idx_reg] <= walk_to;
                        status_reg        <= STATUS_OK;
                        slot_reg          <= 4'(s1_idx_reg);
                        patch_address_reg <= rd_data_reg;
                        patch_action_reg  <= walk_action;
                        last_reg          <= 1'b0;
                    end
                    if (s1_valid_reg && !walking)
                    begin
                        // keep only the lowest slot of each kind
                        if (s1_hit && !set_found_reg)
                        begin
                            set_found_reg <= 1'b1;
                            set_idx_reg   <= s1_idx_reg;
                        end
                        if (s1_state == SLOT_REMOVED && !rem_found_reg)
                        begin
                            rem_found_reg <= 1'b1;
                            rem_idx_reg   <= s1_idx_reg;
                        end
                        if (s1_state == SLOT_UNDEF && !und_found_reg)
                        begin
                            und_found_reg <= 1'b1;
                            und_idx_reg   <= s1_idx_reg;
                        end
                    end
                end
                S_FINISH:
                begin
                    state_reg         <= S_IDLE;
                    done_reg          <= 1'b1;
                    last_reg          <= 1'b1;
                    patch_address_reg <= '0;
                    patch_action_reg  <= ACT_NONE;
                    status_reg        <= fin_status;
                    slot_reg          <= fin_slot;
                    if (op_reg == OP_INSERT && ins_ok)
                    begin
                        slot_state_reg[ins_idx] <= SLOT_SET;
                    end
                    else if (op_reg == OP_REMOVE && set_found_reg)
                    begin
                        slot_state_reg[set_idx_reg] <= SLOT_REMOVED;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    // address store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ins_idx] <= addr_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign patch_address = patch_address_reg;
    assign patch_action  = patch_action_reg;
    assign last          = last_reg;

    a_finish_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH |=> state_reg == S_IDLE)
        else $error("finish state held longer than one cycle");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_CNT)
        else $error("scan counter beyond table");

    a_patch_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !last_reg |-> patch_action_reg != ACT_NONE)
        else $error("intermediate result without patch action");

    a_last_no_patch: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && last_reg |-> patch_action_reg == ACT_NONE && patch_address_reg == '0)
        else $error("closing result carries a patch");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_SCAN || (done_reg && status_reg == STATUS_KIND))
        else $error("popped request neither scanned nor rejected");

endmodule

FILE: rtl/breakpoint_slot_table_core.sv
// top level of the breakpoint slot table
//
// one request channel: func, address and kind are taken at a rising edge with
// start high and busy low. func selects insert, remove, activate all or
// deactivate all; kind only matters for remove.
// results come out one per cycle, each marked by done for exactly one cycle,
// and last is high on the final result of a request. the receiver cannot
// stall, so results are never held back.
// a two-entry queue sits between the intake and the scan engine, so busy only
// rises when two requests wait behind the one being worked on.
// every request except a rejected remove scans the whole table, one slot per
// cycle through the single read port of the address store. a remove with the
// wrong kind is answered the cycle after it leaves the queue.
// a scanning request holds the engine through its scan and finish states before
// the next request can leave the queue; a rejected remove leaves the engine idle,
// ready for the next request.
// activate and deactivate emit one result per patched slot during the scan,
// then one closing result.
// reset clears all slots to undefined and empties the queue; no clearing pass
// is needed since slot addresses are only used for claimed slots.
module breakpoint_slot_table_core
    import bps_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] address,
    input  logic        kind,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  slot,
    output logic [31:0] patch_address,
    output logic [1:0]  patch_action,
    output logic        last
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    bps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .func    (func),
        .address (address),
        .kind    (kind),
        .busy    (busy),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    bps_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .patch_address (patch_address),
        .patch_action  (patch_action),
        .last          (last)
    );

endmodule

FILE: dv/breakpoint_slot_table_checker.sv
// checker for the breakpoint slot table: watches requests, predicts results and compares them
`timescale 1ns / 1ps

module breakpoint_slot_table_checker
    import bps_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] address,
    input  logic        kind,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [3:0]  slot,
    input  logic [31:0] patch_address,
    input  logic [1:0]  patch_action,
    input  logic        last,
    output int          fail_count,
    output int          pending_count,
    output int          results_checked
);

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] patch_address;
        logic [1:0]  patch_action;
        logic        last;
    } table_result_t;

    logic [1:0]    bp_state [NUM_SLOTS];
    logic [31:0]   bp_addr  [NUM_SLOTS];
    table_result_t expected_results [$];

    initial
    begin
        fail_count      = 0;
        pending_count   = 0;
        results_checked = 0;
    end

    function automatic void push_result(input logic [1:0] st, input logic [3:0] sl,
                                        input logic [31:0] pa, input logic [1:0] act,
                                        input logic lst);
        table_result_t r;
        r.status        = st;
        r.slot          = sl;
        r.patch_address = pa;
        r.patch_action  = act;
        r.last          = lst;
        expected_results.push_back(r);
    endfunction

    // install or restore every slot in the from state, then the closing result
    function automatic void predict_walk(input logic [1:0] from_state,
                                         input logic [1:0] to_state,
                                         input logic [1:0] act);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (bp_state[i] == from_state)
            begin
                push_result(STATUS_OK, i[3:0], bp_addr[i], act, 1'b0);
                bp_state[i] = to_state;
            end
        end
        push_result(STATUS_OK, 4'd0, 32'd0, ACT_NONE, 1'b1);
    endfunction

    function automatic void predict_request(input logic [1:0] f, input logic [31:0] a,
                                            input logic k);
        int set_hit;
        int free_slot;
        set_hit   = -1;
        free_slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (set_hit < 0 && bp_state[i] == SLOT_SET && bp_addr[i] == a)
                set_hit = i;
        case (f)
            FUNC_INSERT:
            begin
                // removed slots are reused before untouched ones
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (free_slot < 0 && bp_state[i] == SLOT_REMOVED)
                        free_slot = i;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (free_slot < 0 && bp_state[i] == SLOT_UNDEF)
                        free_slot = i;
                if (set_hit >= 0 || free_slot < 0)
                    push_result(STATUS_UNABLE, 4'd0, 32'd0, ACT_NONE, 1'b1);
                else
                begin
                    bp_state[free_slot] = SLOT_SET;
                    bp_addr[free_slot]  = a;
                    push_result(STATUS_OK, free_slot[3:0], 32'd0, ACT_NONE, 1'b1);
                end
            end
            FUNC_REMOVE:
            begin
                if (k)
                    push_result(STATUS_KIND, 4'd0, 32'd0, ACT_NONE, 1'b1);
                else if (set_hit < 0)
                    push_result(STATUS_NOT_FOUND, 4'd0, 32'd0, ACT_NONE, 1'b1);
                else
                begin
                    bp_state[set_hit] = SLOT_REMOVED;
                    push_result(STATUS_OK, set_hit[3:0], 32'd0, ACT_NONE, 1'b1);
                end
            end
            FUNC_ACTIVATE:
                predict_walk(SLOT_SET, SLOT_ACTIVE, ACT_INSTALL);
            default:
                predict_walk(SLOT_ACTIVE, SLOT_SET, ACT_RESTORE);
        endcase
    endfunction

    task automatic report_mismatch(input string field_name, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
    endtask

    always @(posedge clk)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                bp_state[i] = SLOT_UNDEF;
                bp_addr[i]  = 32'd0;
            end
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0h",
                             $time, status);
                    $display("    slot %0h addr %0h action %0h last %0b",
                             slot, patch_address, patch_action, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status !== status || want.slot !== slot ||
                        want.patch_address !== patch_address ||
                        want.patch_action !== patch_action || want.last !== last)
                    begin
                        if (want.status !== status)
                            report_mismatch("status", 32'(want.status), 32'(status));
                        if (want.slot !== slot)
                            report_mismatch("slot", 32'(want.slot), 32'(slot));
                        if (want.patch_address !== patch_address)
                            report_mismatch("patch_address", want.patch_address, patch_address);
                        if (want.patch_action !== patch_action)
                            report_mismatch("patch_action", 32'(want.patch_action),
                                            32'(patch_action));
                        if (want.last !== last)
                            report_mismatch("last", 32'(want.last), 32'(last));
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict_request(func, address, kind);
        end
        pending_count = expected_results.size();
    end

endmodule

FILE: dv/breakpoint_slot_table_core_tb.sv
// top of the breakpoint slot table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module breakpoint_slot_table_core_tb
    import bps_pkg::*;
();

    localparam int NUM_SLOTS   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 64;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [31:0] address;
    logic        kind;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] patch_address;
    logic [1:0]  patch_action;
    logic        last;

    int fail_count;
    int pending_count;
    int results_checked;
    int requests_sent;
    int sender_idle_pct;
    int cycle_count;

    breakpoint_slot_table_core #(.NUM_SLOTS(NUM_SLOTS)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .address       (address),
        .kind          (kind),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .patch_address (patch_address),
        .patch_action  (patch_action),
        .last          (last)
    );

    breakpoint_slot_table_checker #(.NUM_SLOTS(NUM_SLOTS)) check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .address         (address),
        .kind            (kind),
        .done            (done),
        .status          (status),
        .slot            (slot),
        .patch_address   (patch_address),
        .patch_action    (patch_action),
        .last            (last),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("breakpoint_slot_table_core verification failed");
            $finish;
        end
    end

    // start stays high from one request to the next unless the sender idles
    task automatic send_request(input logic [1:0] f, input logic [31:0] a, input logic k);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start   <= 1'b0;
            func    <= 2'($urandom);
            address <= $urandom;
            kind    <= 1'($urandom);
            @(negedge clk);
        end
        start   <= 1'b1;
        func    <= f;
        address <= a;
        kind    <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
    endtask

    initial
    begin
        logic [31:0] addr_pool [32];
        int          idle_by_phase [3];
        int          span_by_phase [3];
        int          pick;
        int          directed_count;
        logic [1:0]  rf;
        logic [31:0] ra;
        logic        rk;

        idle_by_phase   = '{34, 77, 0};
        span_by_phase   = '{20, 12, 32};
        requests_sent   = 0;
        sender_idle_pct = 34;
        rst_n   = 1'b0;
        start   = 1'b0;
        func    = FUNC_INSERT;
        address = 32'd0;
        kind    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        send_request(FUNC_INSERT, 32'h0000_0000, 1'b0);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 1'b0);
        send_request(FUNC_INSERT, 32'h0000_0000, 1'b0);       // duplicate of a set slot
        send_request(FUNC_REMOVE, 32'h0000_0000, 1'b1);       // wrong kind
        send_request(FUNC_REMOVE, 32'h1234_5678, 1'b0);       // nothing to remove
        send_request(FUNC_ACTIVATE, 32'h0, 1'b0);
        send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0);       // active slots never match
        send_request(FUNC_INSERT, 32'h0000_0000, 1'b0);       // active slot does not block
        send_request(FUNC_DEACTIVATE, 32'h0, 1'b0);
        send_request(FUNC_REMOVE, 32'h0000_0000, 1'b0);
        send_request(FUNC_INSERT, 32'hA5A5_A5A5, 1'b0);       // reuses the removed slot
        for (int n = 0; n < NUM_SLOTS - 3; n++)
            send_request(FUNC_INSERT, 32'h5A5A_0000 + n * 32'h0101, 1'b0);
        send_request(FUNC_INSERT, 32'hDEAD_BEEF, 1'b0);       // table full
        send_request(FUNC_ACTIVATE, 32'h0, 1'b0);
        send_request(FUNC_DEACTIVATE, 32'h0, 1'b0);
        directed_count = requests_sent;

        foreach (addr_pool[i])
            addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;

        // random part: a small address pool keeps duplicates, hits and full tables common
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = idle_by_phase[phase];
            repeat (148)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    rf = FUNC_INSERT;
                else if (pick < 72)
                    rf = FUNC_REMOVE;
                else if (pick < 86)
                    rf = FUNC_ACTIVATE;
                else
                    rf = FUNC_DEACTIVATE;
                if ($urandom_range(99) < 80)
                    ra = addr_pool[$urandom_range(span_by_phase[phase] - 1)];
                else
                    ra = $urandom;
                rk = ($urandom_range(99) < 12);
                send_request(rf, ra, rk);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d requests (%0d directed) across three idling phases",
                 requests_sent, directed_count);
        $display("checked %0d results with %0d failures", results_checked, fail_count);
        if (fail_count == 0)
            $display("breakpoint_slot_table_core verification clean");
        else
            $display("breakpoint_slot_table_core verification failed");
        $finish;
    end

endmodule
